// ----- hw/rtl/lpcpb_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpcpb_pkg: shared types and constants of the progress bar unit
// Geometry constants, derived widths, the queued job and the back FSM states.
// ----------------------------------------------------------------------------
package lpcpb_pkg;

    localparam int PIXELS_PER_CELL = 5;
    localparam int MAX_CELLS       = 16;

    localparam int TIME_W   = 32;
    localparam int COL_W    = 4;
    localparam int NCELL_W  = 5;
    localparam int GLYPH_W  = 6;
    localparam int OCOL_W   = 5;

    localparam int CNT_W    = $clog2(MAX_CELLS + 1);
    localparam int PX_W     = $clog2(MAX_CELLS * PIXELS_PER_CELL + 1);
    localparam int LIT_W    = $clog2(PIXELS_PER_CELL + 1);
    localparam int PROD_W   = TIME_W + PX_W;
    localparam int DCNT_W   = $clog2(PROD_W + 1);

    localparam int Q_DEPTH  = 2;
    localparam int Q_PTR_W  = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
    localparam int Q_CNT_W  = $clog2(Q_DEPTH + 1);

    localparam logic [GLYPH_W-1:0] SPACE_CODE = GLYPH_W'(32);

    // One bar request after classification
    typedef struct packed {
        logic                bar_row;
        logic [COL_W-1:0]    col0;
        logic [CNT_W-1:0]    cells;
        logic                full_bar;   // zero total: product holds total pixels
        logic [PROD_W-1:0]   prod;
        logic [TIME_W-1:0]   total;
    } t_job;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_DIV,
        BK_EMIT
    } t_back_state;

endpackage

// ----- hw/rtl/lpcpb_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpcpb_front: request intake
// Saturates the cell count, clamps elapsed time, forms the scaled product and
// pushes the job into the queue. Zero-cell requests are taken and dropped.
// ----------------------------------------------------------------------------
module lpcpb_front
    import lpcpb_pkg::*;
(
    input  logic                i_valid,
    output logic                o_ready,
    input  logic                i_bar_row,
    input  logic [COL_W-1:0]    i_start_column,
    input  logic [NCELL_W-1:0]  i_bar_cells,
    input  logic [TIME_W-1:0]   i_elapsed_ms,
    input  logic [TIME_W-1:0]   i_total_ms,
    input  t_q_stat             i_q_stat,
    output logic                o_push,
    output t_job                o_job
);

    logic [CNT_W-1:0]  cells_sat;
    logic [PX_W-1:0]   total_px;
    logic [TIME_W-1:0] elapsed_c;
    logic              zero_total;

    always_comb begin
        if (32'(i_bar_cells) > MAX_CELLS) begin
            cells_sat = CNT_W'(MAX_CELLS);
        end else begin
            cells_sat = CNT_W'(i_bar_cells);
        end
        total_px   = PX_W'(32'(cells_sat) * 32'(PIXELS_PER_CELL));
        zero_total = (i_total_ms == '0);
        elapsed_c  = (i_elapsed_ms > i_total_ms) ? i_total_ms : i_elapsed_ms;
    end

    assign o_ready = !i_q_stat.full;
    assign o_push  = i_valid && !i_q_stat.full && (cells_sat != '0);

    always_comb begin
        o_job.bar_row  = i_bar_row;
        o_job.col0     = i_start_column;
        o_job.cells    = cells_sat;
        o_job.full_bar = zero_total;
        o_job.total    = i_total_ms;
        if (zero_total) begin
            o_job.prod = PROD_W'(total_px);
        end else begin
            o_job.prod = PROD_W'(elapsed_c) * PROD_W'(total_px);
        end
    end

endmodule

// ----- hw/rtl/lpcpb_queue.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpcpb_queue: job queue
// Small register FIFO between intake and the divide/emit engine.
// ----------------------------------------------------------------------------
module lpcpb_queue
    import lpcpb_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_job    i_job,
    input  logic    i_pop,
    output t_job    o_job,
    output t_q_stat o_stat
);

    t_job               r_mem [Q_DEPTH];
    logic [Q_PTR_W-1:0] r_wr_ptr;
    logic [Q_PTR_W-1:0] r_rd_ptr;
    logic [Q_CNT_W-1:0] r_count;
    logic               do_push;
    logic               do_pop;

    assign o_stat.full  = (32'(r_count) == Q_DEPTH);
    assign o_stat.empty = (r_count == '0);
    assign do_push      = i_push && !o_stat.full;
    assign do_pop       = i_pop && !o_stat.empty;
    assign o_job        = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (32'(r_wr_ptr) == Q_DEPTH - 1) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (32'(r_rd_ptr) == Q_DEPTH - 1) ? '0 : r_rd_ptr + 1'b1;
            end
            unique case ({do_push, do_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

// ----- hw/rtl/lpcpb_back.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpcpb_back: divide and glyph emitter
// Restoring divide, one quotient bit per cycle, then one glyph per cycle into
// an output register while that register is free; a stalled glyph holds the emitter.
// ----------------------------------------------------------------------------
module lpcpb_back
    import lpcpb_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_q_stat             i_q_stat,
    input  t_job                i_job,
    output logic                o_pop,
    output logic                o_valid,
    input  logic                i_ready,
    output logic [GLYPH_W-1:0]  o_glyph_code,
    output logic                o_cell_row,
    output logic [OCOL_W-1:0]   o_cell_column,
    output logic                o_last_cell
);

    t_back_state         r_state, n_state;
    logic [TIME_W:0]     r_rem, n_rem;
    logic [PROD_W-1:0]   r_quo, n_quo;
    logic [TIME_W-1:0]   r_total, n_total;
    logic [DCNT_W-1:0]   r_dcnt, n_dcnt;
    logic [PX_W-1:0]     r_filled, n_filled;
    logic [PX_W-1:0]     r_start, n_start;
    logic [CNT_W-1:0]    r_idx, n_idx;
    logic [CNT_W-1:0]    r_cells, n_cells;
    logic [COL_W-1:0]    r_col0, n_col0;
    logic                r_row, n_row;

    logic                r_out_valid, n_out_valid;
    logic [GLYPH_W-1:0]  r_glyph, n_glyph;
    logic                r_orow, n_orow;
    logic [OCOL_W-1:0]   r_ocol, n_ocol;
    logic                r_olast, n_olast;

    logic [TIME_W:0]     rem_sh;
    logic                q_bit;
    logic [PX_W-1:0]     diff;
    logic [LIT_W-1:0]    lit;
    logic                out_free;
    logic                is_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= BK_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem    <= n_rem;
        r_quo    <= n_quo;
        r_total  <= n_total;
        r_dcnt   <= n_dcnt;
        r_filled <= n_filled;
        r_start  <= n_start;
        r_idx    <= n_idx;
        r_cells  <= n_cells;
        r_col0   <= n_col0;
        r_row    <= n_row;
        r_glyph  <= n_glyph;
        r_orow   <= n_orow;
        r_ocol   <= n_ocol;
        r_olast  <= n_olast;
    end

    // Divide step and per-cell glyph
    always_comb begin
        rem_sh = {r_rem[TIME_W-1:0], r_quo[PROD_W-1]};
        q_bit  = (rem_sh >= {1'b0, r_total});
        diff   = r_filled - r_start;
        if (r_filled <= r_start) begin
            lit = '0;
        end else if (32'(diff) >= PIXELS_PER_CELL) begin
            lit = LIT_W'(PIXELS_PER_CELL);
        end else begin
            lit = LIT_W'(diff);
        end
        is_last  = (r_idx + 1'b1 == r_cells);
        out_free = !r_out_valid || i_ready;
    end

    always_comb begin
        n_state     = r_state;
        n_rem       = r_rem;
        n_quo       = r_quo;
        n_total     = r_total;
        n_dcnt      = r_dcnt;
        n_filled    = r_filled;
        n_start     = r_start;
        n_idx       = r_idx;
        n_cells     = r_cells;
        n_col0      = r_col0;
        n_row       = r_row;
        n_out_valid = r_out_valid && !i_ready;
        n_glyph     = r_glyph;
        n_orow      = r_orow;
        n_ocol      = r_ocol;
        n_olast     = r_olast;
        o_pop       = 1'b0;

        unique case (r_state)
            BK_IDLE: begin
                if (!i_q_stat.empty) begin
                    o_pop    = 1'b1;
                    n_row    = i_job.bar_row;
                    n_col0   = i_job.col0;
                    n_cells  = i_job.cells;
                    n_total  = i_job.total;
                    n_quo    = i_job.prod;
                    n_rem    = '0;
                    n_dcnt   = '0;
                    n_idx    = '0;
                    n_start  = '0;
                    n_filled = i_job.prod[PX_W-1:0];
                    n_state  = i_job.full_bar ? BK_EMIT : BK_DIV;
                end
            end
            BK_DIV: begin
                n_rem  = q_bit ? rem_sh - {1'b0, r_total} : rem_sh;
                n_quo  = {r_quo[PROD_W-2:0], q_bit};
                n_dcnt = r_dcnt + 1'b1;
                if (32'(r_dcnt) == PROD_W - 1) begin
                    // quotient never exceeds the bar's pixel count
                    n_filled = PX_W'({r_quo[PROD_W-2:0], q_bit});
                    n_state  = BK_EMIT;
                end
            end
            BK_EMIT: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_glyph     = (lit == '0) ? SPACE_CODE : GLYPH_W'(lit - 1'b1);
                    n_orow      = r_row;
                    n_ocol      = OCOL_W'(r_col0) + OCOL_W'(r_idx);
                    n_olast     = is_last;
                    n_idx       = r_idx + 1'b1;
                    n_start     = r_start + PX_W'(PIXELS_PER_CELL);
                    if (is_last) begin
                        n_state = BK_IDLE;
                    end
                end
            end
            default: n_state = BK_IDLE;
        endcase
    end

    assign o_valid       = r_out_valid;
    assign o_glyph_code  = r_glyph;
    assign o_cell_row    = r_orow;
    assign o_cell_column = r_ocol;
    assign o_last_cell   = r_olast;

endmodule

// ----- hw/rtl/lcd_partial_cell_progress_bar_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcd_partial_cell_progress_bar_unit: smooth progress bar glyph generator
// Turns one bar request into one glyph beat per cell, left to right.
// ----------------------------------------------------------------------------
//  channel   direction  handshake            payload
//  request   in         i_valid / o_ready    bar_row, start_column, bar_cells,
//                                            elapsed_ms, total_ms
//  glyph     out        o_valid / i_ready    glyph_code, cell_row, cell_column,
//                                            last_cell
//
//  A request is popped from the queue, runs through the restoring divider
//  (one bit of the 39-bit product per cycle, skipped for a zero total), then
//  emits one glyph per cell.
//  Requests are taken while the queue has room; zero-cell ones emit nothing.
//  A stalled glyph holds in the output register and stops the emitter only.
//  Synchronous active-low reset empties the queue and the output register.
// ----------------------------------------------------------------------------
module lcd_partial_cell_progress_bar_unit
    import lpcpb_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  logic                i_bar_row,
    input  logic [COL_W-1:0]    i_start_column,
    input  logic [NCELL_W-1:0]  i_bar_cells,
    input  logic [TIME_W-1:0]   i_elapsed_ms,
    input  logic [TIME_W-1:0]   i_total_ms,
    output logic                o_valid,
    input  logic                i_ready,
    output logic [GLYPH_W-1:0]  o_glyph_code,
    output logic                o_cell_row,
    output logic [OCOL_W-1:0]   o_cell_column,
    output logic                o_last_cell
);

    t_q_stat q_stat;
    t_job    push_job;
    t_job    head_job;
    logic    push;
    logic    pop;

    lpcpb_front u_front (
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_bar_row      (i_bar_row),
        .i_start_column (i_start_column),
        .i_bar_cells    (i_bar_cells),
        .i_elapsed_ms   (i_elapsed_ms),
        .i_total_ms     (i_total_ms),
        .i_q_stat       (q_stat),
        .o_push         (push),
        .o_job          (push_job)
    );

    lpcpb_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (push_job),
        .i_pop   (pop),
        .o_job   (head_job),
        .o_stat  (q_stat)
    );

    lpcpb_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_q_stat      (q_stat),
        .i_job         (head_job),
        .o_pop         (pop),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_glyph_code  (o_glyph_code),
        .o_cell_row    (o_cell_row),
        .o_cell_column (o_cell_column),
        .o_last_cell   (o_last_cell)
    );

endmodule
